[design/pjsc_pkg.sv]
// ----------------------------------------------------------------------------
// pjsc_pkg: shared types and constants of the png/jpeg stream carver
// Header byte patterns, field widths, state machine codes and the structs that
// travel between the window control, the region tracker and the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package pjsc_pkg;

   localparam int WIN_BYTES       = 10;
   localparam int MAX_BLOCK_BYTES = 16777216;
   localparam int POS_W           = $clog2(MAX_BLOCK_BYTES) + 1;
   localparam int START_W         = 24;
   localparam int LEN_W           = 25;
   localparam int OFFS_W          = 34;
   localparam int CHB_W           = 56;
   localparam int FLUSH_W         = $clog2(WIN_BYTES - 1);

   typedef logic [POS_W-1:0]   pos_type;
   typedef logic [START_W-1:0] start_type;
   typedef logic [LEN_W-1:0]   len_type;
   typedef logic [OFFS_W-1:0]  offs_type;
   typedef logic [CHB_W-1:0]   chb_type;
   typedef logic [FLUSH_W-1:0] flush_type;

   // index 0 is the oldest byte
   typedef logic [WIN_BYTES-1:0][7:0] window_type;

   localparam pos_type   POS_JUDGE  = pos_type'(WIN_BYTES - 1);
   localparam pos_type   POS_LIMIT  = pos_type'(MAX_BLOCK_BYTES);
   localparam flush_type FLUSH_LAST = flush_type'(WIN_BYTES - 2);

   localparam logic [63:0] PNG_SIG   = 64'h89504E470D0A1A0A;
   localparam logic [7:0]  MARKER    = 8'hFF;
   localparam logic [7:0]  SOI_CODE  = 8'hD8;
   localparam logic [7:0]  EOI_CODE  = 8'hD9;
   localparam logic [7:0]  APP0_CODE = 8'hE0;
   localparam logic [7:0]  APP1_CODE = 8'hE1;
   localparam logic [31:0] JFIF_ID   = 32'h4A464946;
   localparam logic [31:0] EXIF_ID   = 32'h45786966;
   localparam logic [31:0] IEND_TYPE = 32'h49454E44;

   localparam int       CHUNK_OVERHEAD = 12;
   localparam offs_type FIRST_CHUNK    = offs_type'(8);

   localparam logic FMT_PNG  = 1'b0;
   localparam logic FMT_JPEG = 1'b1;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_FLUSH,
      ST_PEND,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   length;
      logic               format;
      logic               last;
   } result_type;

   typedef struct packed {
      logic               feed;
      logic               open;
      logic               format;
      logic [START_W-1:0] start;
      logic               clear;
   } region_ctrl_type;

   typedef struct packed {
      logic               valid;
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   length;
      logic               format;
   } region_close_type;

endpackage

`default_nettype wire

[design/pjsc_header.sv]
// ----------------------------------------------------------------------------
// pjsc_header: image header detector
// Compares the ten byte look-ahead window against the png signature and the
// jpeg soi + app0 jfif / soi + app1 exif headers.
// ----------------------------------------------------------------------------
`default_nettype none

module pjsc_header (
   input  wire pjsc_pkg::window_type window,
   output logic                     hit,
   output logic                     format
);

   logic png_hit;
   logic jpeg_pre;
   logic jfif_hit;
   logic exif_hit;

   always_comb begin
      png_hit  = {window[0], window[1], window[2], window[3],
                  window[4], window[5], window[6], window[7]} == pjsc_pkg::PNG_SIG;
      jpeg_pre = (window[0] == pjsc_pkg::MARKER) && (window[1] == pjsc_pkg::SOI_CODE) &&
                 (window[2] == pjsc_pkg::MARKER);
      jfif_hit = (window[3] == pjsc_pkg::APP0_CODE) &&
                 ({window[6], window[7], window[8], window[9]} == pjsc_pkg::JFIF_ID);
      exif_hit = (window[3] == pjsc_pkg::APP1_CODE) &&
                 ({window[6], window[7], window[8], window[9]} == pjsc_pkg::EXIF_ID);
      hit      = png_hit || (jpeg_pre && (jfif_hit || exif_hit));
      format   = png_hit ? pjsc_pkg::FMT_PNG : pjsc_pkg::FMT_JPEG;
   end

endmodule

`default_nettype wire

[design/pjsc_region.sv]
// ----------------------------------------------------------------------------
// pjsc_region: carved region tracker
// Holds the open region and consumes one byte per feed: walks the png chunk
// chain to iend, or tracks the last jpeg eoi marker. Reports the close result.
// ----------------------------------------------------------------------------
`default_nettype none

module pjsc_region (
   input  wire                            clock,
   input  wire                            reset,
   input  wire pjsc_pkg::region_ctrl_type ctrl,
   input  wire [7:0]                      feed_byte,
   output pjsc_pkg::region_close_type     close
);

   logic                 open_ff,   open_in;
   logic                 fmt_ff,    fmt_in;
   pjsc_pkg::start_type  start_ff,  start_in;
   pjsc_pkg::offs_type   nco_ff,    nco_in;
   pjsc_pkg::chb_type    chb_ff,    chb_in;
   logic                 found_ff,  found_in;
   pjsc_pkg::len_type    tlen_ff,   tlen_in;
   logic                 prevff_ff, prevff_in;
   pjsc_pkg::len_type    rel_ff,    rel_in;

   logic                 eff_open;
   logic                 eff_fmt;
   pjsc_pkg::start_type  eff_start;
   pjsc_pkg::offs_type   eff_nco;
   pjsc_pkg::chb_type    eff_chb;
   logic                 eff_found;
   pjsc_pkg::len_type    eff_tlen;
   logic                 eff_prevff;
   pjsc_pkg::len_type    eff_rel;

   logic [pjsc_pkg::OFFS_W:0] diff;
   logic                      in_hdr;
   logic                      hdr_done;
   logic [31:0]               chunk_size;
   logic [31:0]               chunk_kind;
   pjsc_pkg::offs_type        nco_add;

   assign close.valid  = open_ff && found_ff;
   assign close.start  = start_ff;
   assign close.length = tlen_ff;
   assign close.format = fmt_ff;

   // a header opens the region before its own byte is fed
   always_comb begin
      if (ctrl.open) begin
         eff_open   = 1'b1;
         eff_fmt    = ctrl.format;
         eff_start  = ctrl.start;
         eff_nco    = pjsc_pkg::FIRST_CHUNK;
         eff_chb    = '0;
         eff_found  = 1'b0;
         eff_tlen   = '0;
         eff_prevff = 1'b0;
         eff_rel    = '0;
      end else begin
         eff_open   = open_ff;
         eff_fmt    = fmt_ff;
         eff_start  = start_ff;
         eff_nco    = nco_ff;
         eff_chb    = chb_ff;
         eff_found  = found_ff;
         eff_tlen   = tlen_ff;
         eff_prevff = prevff_ff;
         eff_rel    = rel_ff;
      end
   end

   always_comb begin
      diff       = {1'b0, pjsc_pkg::offs_type'(eff_rel)} - {1'b0, eff_nco};
      in_hdr     = !diff[pjsc_pkg::OFFS_W] && (diff[pjsc_pkg::OFFS_W-1:3] == '0);
      hdr_done   = diff[2:0] == 3'd7;
      chunk_size = eff_chb[pjsc_pkg::CHB_W-1 -: 32];
      chunk_kind = {eff_chb[23:0], feed_byte};
      nco_add    = eff_nco + pjsc_pkg::offs_type'(pjsc_pkg::CHUNK_OVERHEAD) +
                   pjsc_pkg::offs_type'(chunk_size);
   end

   always_comb begin
      open_in   = eff_open;
      fmt_in    = eff_fmt;
      start_in  = eff_start;
      nco_in    = eff_nco;
      chb_in    = eff_chb;
      found_in  = eff_found;
      tlen_in   = eff_tlen;
      prevff_in = eff_prevff;
      rel_in    = eff_rel;
      if (ctrl.feed && eff_open) begin
         rel_in = eff_rel + pjsc_pkg::len_type'(1);
         if (eff_fmt == pjsc_pkg::FMT_PNG) begin
            if (!eff_found && in_hdr) begin
               chb_in = {eff_chb[pjsc_pkg::CHB_W-9:0], feed_byte};
               if (hdr_done) begin
                  if (chunk_kind == pjsc_pkg::IEND_TYPE) begin
                     found_in = 1'b1;
                     tlen_in  = eff_nco[pjsc_pkg::LEN_W-1:0] +
                                pjsc_pkg::len_type'(pjsc_pkg::CHUNK_OVERHEAD);
                  end else begin
                     nco_in = nco_add;
                  end
               end
            end
         end else begin
            if (eff_prevff && (feed_byte == pjsc_pkg::EOI_CODE) && (eff_rel != '0)) begin
               found_in = 1'b1;
               tlen_in  = eff_rel + pjsc_pkg::len_type'(1);
            end
            prevff_in = feed_byte == pjsc_pkg::MARKER;
         end
      end
      if (ctrl.clear) begin
         open_in   = 1'b0;
         fmt_in    = 1'b0;
         start_in  = '0;
         nco_in    = '0;
         chb_in    = '0;
         found_in  = 1'b0;
         tlen_in   = '0;
         prevff_in = 1'b0;
         rel_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff   <= 1'b0;
         fmt_ff    <= 1'b0;
         start_ff  <= '0;
         nco_ff    <= '0;
         chb_ff    <= '0;
         found_ff  <= 1'b0;
         tlen_ff   <= '0;
         prevff_ff <= 1'b0;
         rel_ff    <= '0;
      end else begin
         open_ff   <= open_in;
         fmt_ff    <= fmt_in;
         start_ff  <= start_in;
         nco_ff    <= nco_in;
         chb_ff    <= chb_in;
         found_ff  <= found_in;
         tlen_ff   <= tlen_in;
         prevff_ff <= prevff_in;
         rel_ff    <= rel_in;
      end
   end

endmodule

`default_nettype wire

[design/pjsc_rsp_fifo.sv]
// ----------------------------------------------------------------------------
// pjsc_rsp_fifo: two entry result queue
// Decouples the result channel from the byte scan so a byte can be taken while
// an earlier result is still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module pjsc_rsp_fifo (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   input  wire pjsc_pkg::result_type push_data,
   input  wire                       pop_stall,
   output logic                      out_valid,
   output pjsc_pkg::result_type      out_data,
   output logic                      full
);

   pjsc_pkg::result_type slot0_ff, slot0_in;
   pjsc_pkg::result_type slot1_ff, slot1_in;
   logic [1:0]           count_ff, count_in;
   logic                 pop;
   logic [1:0]           wr_idx;

   assign out_valid = count_ff != 2'd0;
   assign out_data  = slot0_ff;
   assign full      = count_ff == 2'd2;
   assign pop       = out_valid && !pop_stall;
   assign wr_idx    = count_ff - {1'b0, pop};

   always_comb begin
      slot0_in = pop ? slot1_ff : slot0_ff;
      slot1_in = slot1_ff;
      if (push) begin
         if (wr_idx == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
      end
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

[design/png_jpeg_stream_carver_top.sv]
// ----------------------------------------------------------------------------
// png_jpeg_stream_carver_top: png/jpeg image carver for one data block
// Scans a byte stream through a ten byte look-ahead window and reports the
// start, length and format of every png or jpeg image carved from the block.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle unless held off; each byte is judged in the
// cycle it is taken, with header compare and region update done between the
// look-ahead window register and the two entry result queue. Input is held off
// while that queue is full and during the end of block. The flagged last byte
// starts the end of block: the flush state pushes the window tail through the
// region tracker, then the pend and final states hand the last results to the
// queue while it has room, after which the block is ready for the next data
// block.
`default_nettype none

module png_jpeg_stream_carver_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_last_byte,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [23:0] rsp_image_start,
   output logic [24:0] rsp_image_length,
   output logic        rsp_image_format,
   output logic        rsp_last_of_run
);

   pjsc_pkg::state_type   state_ff, state_in;
   pjsc_pkg::window_type  window_ff, window_in;
   pjsc_pkg::pos_type     pos_ff, pos_in;
   pjsc_pkg::flush_type   flush_cnt_ff, flush_cnt_in;
   logic                  pend_valid_ff, pend_valid_in;
   pjsc_pkg::result_type  pend_ff, pend_in;

   pjsc_pkg::window_type      window_new;
   logic                      hdr_hit;
   logic                      hdr_fmt;
   pjsc_pkg::region_ctrl_type ctrl;
   pjsc_pkg::region_close_type close;
   pjsc_pkg::result_type      push_data;
   pjsc_pkg::result_type      rsp_data;
   logic                      push;
   logic                      fifo_full;
   logic                      accept;
   logic                      step;
   logic                      judge;
   logic                      header_close;
   logic                      done;

   assign window_new   = {req_data_byte, window_ff[pjsc_pkg::WIN_BYTES-1:1]};
   assign req_stall    = (state_ff != pjsc_pkg::ST_RUN) || fifo_full;
   assign accept       = req_valid && !req_stall;
   assign step         = accept && (pos_ff < pjsc_pkg::POS_LIMIT);
   assign judge        = step && (pos_ff >= pjsc_pkg::POS_JUDGE);
   assign header_close = judge && hdr_hit && close.valid;
   assign done         = (state_ff == pjsc_pkg::ST_FINAL) && !fifo_full;

   pjsc_header u_header (
      .window (window_new),
      .hit    (hdr_hit),
      .format (hdr_fmt)
   );

   pjsc_region u_region (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .feed_byte (window_ff[1]),
      .close     (close)
   );

   pjsc_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .full      (fifo_full)
   );

   assign rsp_image_start  = rsp_data.start;
   assign rsp_image_length = rsp_data.length;
   assign rsp_image_format = rsp_data.format;
   assign rsp_last_of_run  = rsp_data.last;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pjsc_pkg::ST_RUN: begin
            if (accept && req_last_byte) begin
               state_in = pjsc_pkg::ST_FLUSH;
            end
         end
         pjsc_pkg::ST_FLUSH: begin
            if (flush_cnt_ff == pjsc_pkg::FLUSH_LAST) begin
               state_in = pjsc_pkg::ST_PEND;
            end
         end
         pjsc_pkg::ST_PEND: begin
            if (!pend_valid_ff || !fifo_full) begin
               state_in = pjsc_pkg::ST_FINAL;
            end
         end
         pjsc_pkg::ST_FINAL: begin
            if (!fifo_full) begin
               state_in = pjsc_pkg::ST_RUN;
            end
         end
         default: begin
            state_in = pjsc_pkg::ST_RUN;
         end
      endcase
   end

   // control outputs
   always_comb begin
      ctrl      = '0;
      push      = 1'b0;
      push_data = '0;
      case (state_ff)
         pjsc_pkg::ST_RUN: begin
            ctrl.feed   = judge;
            ctrl.open   = judge && hdr_hit;
            ctrl.format = hdr_fmt;
            ctrl.start  = pjsc_pkg::start_type'(pos_ff - pjsc_pkg::POS_JUDGE);
            push        = header_close && !req_last_byte;
            push_data   = '{start: close.start, length: close.length,
                            format: close.format, last: 1'b1};
         end
         pjsc_pkg::ST_FLUSH: begin
            ctrl.feed = 1'b1;
         end
         pjsc_pkg::ST_PEND: begin
            push      = pend_valid_ff && !fifo_full;
            push_data = '{start: pend_ff.start, length: pend_ff.length,
                          format: pend_ff.format, last: !close.valid};
         end
         pjsc_pkg::ST_FINAL: begin
            ctrl.clear = !fifo_full;
            push       = close.valid && !fifo_full;
            push_data  = '{start: close.start, length: close.length,
                           format: close.format, last: 1'b1};
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   // window, position and held result
   always_comb begin
      window_in     = window_ff;
      pos_in        = pos_ff;
      flush_cnt_in  = '0;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (step) begin
         window_in = window_new;
         pos_in    = pos_ff + pjsc_pkg::pos_type'(1);
      end
      if (accept && req_last_byte) begin
         pend_valid_in = header_close;
         pend_in       = '{start: close.start, length: close.length,
                           format: close.format, last: 1'b0};
      end
      if (state_ff == pjsc_pkg::ST_FLUSH) begin
         window_in    = {8'h00, window_ff[pjsc_pkg::WIN_BYTES-1:1]};
         flush_cnt_in = flush_cnt_ff + pjsc_pkg::flush_type'(1);
      end
      if (done) begin
         window_in     = '0;
         pos_in        = '0;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (reset) begin
         state_ff      <= pjsc_pkg::ST_RUN;
         window_ff     <= '0;
         pos_ff        <= '0;
         flush_cnt_ff  <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         window_ff     <= window_in;
         pos_ff        <= pos_in;
         flush_cnt_ff  <= flush_cnt_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   a_stall_when_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != pjsc_pkg::ST_RUN |-> req_stall)
      else $error("request taken outside the scan state");

   a_last_starts_flush: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_byte |=> state_ff == pjsc_pkg::ST_FLUSH)
      else $error("last byte did not start the window flush");

   a_flush_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pjsc_pkg::ST_FLUSH) && (flush_cnt_ff == pjsc_pkg::FLUSH_LAST)
      |=> state_ff == pjsc_pkg::ST_PEND)
      else $error("window flush did not end after the tail bytes");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_full)
      else $error("result pushed into a full queue");

endmodule

`default_nettype wire

[dv/png_jpeg_stream_carver_top_tb.sv]
// ----------------------------------------------------------------------------
// png_jpeg_stream_carver_top_tb: self-checking bench for the png/jpeg carver
// Sends data blocks built from png and jpeg images with random content, noise,
// broken headers and cut-off tails. Every accepted request runs through a
// behavioral carver that queues the expected image results, and each result
// taken from the block is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module png_jpeg_stream_carver_top_tb;
   import pjsc_pkg::*;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } byte_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   wire         req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   wire         rsp_valid;
   logic        rsp_stall = 1'b0;
   wire  [23:0] rsp_image_start;
   wire  [24:0] rsp_image_length;
   wire         rsp_image_format;
   wire         rsp_last_of_run;

   png_jpeg_stream_carver_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_image_start  (rsp_image_start),
      .rsp_image_length (rsp_image_length),
      .rsp_image_format (rsp_image_format),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   byte_req_type pending_q[$];
   byte_req_type staged_q[$];
   logic [7:0]   blk_bytes[$];
   result_type   image_q[$];
   result_type   step_q[$];
   result_type   image_want;

   int   req_count = 0;
   int   total_reqs = 1 << 30;
   int   err_count = 0;
   int   send_gap = 0;
   int   stall_left = 0;
   logic hold_receiver = 1'b0;

   wire tail_quiet = (req_count + 150 >= total_reqs);
   wire idle_phase = !tail_quiet && ((req_count / 120) % 3 != 2);

   // carver state
   logic [7:0]  scan_win [WIN_BYTES];
   logic [63:0] scan_pos;
   logic        cur_open;
   logic        cur_fmt;
   logic [63:0] cur_start;
   logic [63:0] chunk_at;
   logic [63:0] chunk_hdr;
   logic        end_found;
   logic [63:0] end_len;
   logic        last_ff;

   initial begin
      forever #10 clock = ~clock;
   end

   task automatic carver_clear();
      foreach (scan_win[i]) scan_win[i] = 8'h00;
      scan_pos  = '0;
      cur_open  = 1'b0;
      cur_fmt   = FMT_PNG;
      cur_start = '0;
      chunk_at  = '0;
      chunk_hdr = '0;
      end_found = 1'b0;
      end_len   = '0;
      last_ff   = 1'b0;
   endtask

   function automatic logic header_in_window(output logic fmt);
      logic [63:0] sig8;
      logic [31:0] id4;
      sig8 = {scan_win[0], scan_win[1], scan_win[2], scan_win[3],
              scan_win[4], scan_win[5], scan_win[6], scan_win[7]};
      id4  = {scan_win[6], scan_win[7], scan_win[8], scan_win[9]};
      fmt  = FMT_PNG;
      if (sig8 == PNG_SIG) return 1'b1;
      fmt = FMT_JPEG;
      if (scan_win[0] == MARKER && scan_win[1] == SOI_CODE && scan_win[2] == MARKER) begin
         if (scan_win[3] == APP0_CODE && id4 == JFIF_ID) return 1'b1;
         if (scan_win[3] == APP1_CODE && id4 == EXIF_ID) return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic region_take(input logic [7:0] b, input logic [63:0] pos);
      logic [63:0] r;
      if (!cur_open) return;
      r = pos - cur_start;
      if (cur_fmt == FMT_PNG) begin
         if (!end_found && r >= chunk_at && r < chunk_at + 8) begin
            chunk_hdr = {chunk_hdr[55:0], b};
            if (r == chunk_at + 7) begin
               if (chunk_hdr[31:0] == IEND_TYPE) begin
                  end_found = 1'b1;
                  end_len   = chunk_at + CHUNK_OVERHEAD;
               end else begin
                  chunk_at = chunk_at + CHUNK_OVERHEAD + {32'h0, chunk_hdr[63:32]};
               end
            end
         end
      end else begin
         if (last_ff && b == EOI_CODE && r >= 1) begin
            end_found = 1'b1;
            end_len   = r + 1;
         end
         last_ff = (b == MARKER);
      end
   endtask

   task automatic close_region();
      result_type res;
      if (cur_open && end_found) begin
         res.start  = cur_start[23:0];
         res.length = end_len[24:0];
         res.format = cur_fmt;
         res.last   = 1'b0;
         step_q.push_back(res);
      end
      cur_open = 1'b0;
   endtask

   task automatic carve_predict(input logic [7:0] b, input logic last_flag);
      logic        fmt;
      logic [63:0] q;
      step_q.delete();
      if (scan_pos < MAX_BLOCK_BYTES) begin
         for (int i = 0; i < WIN_BYTES - 1; i++) scan_win[i] = scan_win[i + 1];
         scan_win[WIN_BYTES - 1] = b;
         scan_pos = scan_pos + 1;
         if (scan_pos >= WIN_BYTES) begin
            q = scan_pos - WIN_BYTES;
            if (header_in_window(fmt)) begin
               close_region();
               cur_open  = 1'b1;
               cur_fmt   = fmt;
               cur_start = q;
               chunk_at  = 64'(FIRST_CHUNK);
               chunk_hdr = '0;
               end_found = 1'b0;
               end_len   = '0;
               last_ff   = 1'b0;
            end
            region_take(scan_win[0], q);
         end
      end
      if (last_flag) begin
         if (scan_pos >= WIN_BYTES) begin
            for (int i = 1; i < WIN_BYTES; i++)
               region_take(scan_win[i], scan_pos - WIN_BYTES + i);
         end
         close_region();
         carver_clear();
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) image_q.push_back(step_q[i]);
   endtask

   // block building
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return MARKER;
         1: return EOI_CODE;
         2: return 8'h00;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic put_bytes(input logic [63:0] v, input int n);
      for (int i = n - 1; i >= 0; i--) blk_bytes.push_back(v[8*i +: 8]);
   endtask

   task automatic add_noise(input int n);
      repeat (n) blk_bytes.push_back(pick_byte());
   endtask

   task automatic add_png();
      int          chunks;
      int          body;
      logic [31:0] clen;
      put_bytes(PNG_SIG, 8);
      chunks = $urandom_range(0, 2);
      repeat (chunks) begin
         clen = $urandom_range(0, 6);
         if ($urandom_range(0, 11) == 0) clen = $urandom;
         body = (clen > 6) ? $urandom_range(0, 6) : clen;
         put_bytes(clen, 4);
         put_bytes($urandom, 4);
         add_noise(body);
         put_bytes($urandom, 4);
      end
      if ($urandom_range(0, 7) != 0) begin
         put_bytes(64'h0, 4);
         put_bytes(IEND_TYPE, 4);
         if ($urandom_range(0, 3) != 0) put_bytes($urandom, 4);
      end
   endtask

   task automatic add_jpeg();
      logic app1;
      app1 = $urandom_range(0, 1);
      put_bytes({MARKER, SOI_CODE, MARKER, (app1 ? APP1_CODE : APP0_CODE)}, 4);
      add_noise(2);
      // occasionally the wrong identifier for the app marker
      if ($urandom_range(0, 9) == 0) put_bytes(app1 ? JFIF_ID : EXIF_ID, 4);
      else put_bytes(app1 ? EXIF_ID : JFIF_ID, 4);
      add_noise($urandom_range(0, 12));
      if ($urandom_range(0, 7) != 0) put_bytes({MARKER, EOI_CODE}, 2);
      if ($urandom_range(0, 3) == 0) add_noise($urandom_range(0, 4));
   endtask

   task automatic seal_block();
      byte_req_type item;
      if (blk_bytes.size() == 0) blk_bytes.push_back(pick_byte());
      foreach (blk_bytes[i]) begin
         item.data = blk_bytes[i];
         item.last = (i == blk_bytes.size() - 1);
         staged_q.push_back(item);
      end
      blk_bytes.delete();
   endtask

   task automatic build_block();
      int segs;
      int kind;
      if ($urandom_range(0, 9) == 0) begin
         add_noise($urandom_range(1, 9));
      end else begin
         segs = $urandom_range(1, 4);
         repeat (segs) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) add_png();
            else if (kind < 8) add_jpeg();
            else add_noise($urandom_range(0, 12));
         end
         // cut-off tail
         if ($urandom_range(0, 5) == 0 && blk_bytes.size() > 8) begin
            repeat ($urandom_range(1, 6)) void'(blk_bytes.pop_back());
         end
      end
      seal_block();
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid     <= 1'b0;
         req_data_byte <= 8'h00;
         req_last_byte <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            carve_predict(req_data_byte, req_last_byte);
            req_count++;
            if (idle_phase && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 15);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0 || pending_q.size() == 0) begin
               if (send_gap > 0) send_gap--;
               req_valid <= 1'b0;
            end else begin
               req_valid     <= 1'b1;
               req_data_byte <= pending_q[0].data;
               req_last_byte <= pending_q[0].last;
               void'(pending_q.pop_front());
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (image_q.size() == 0) begin
               $error("unexpected image result: start %0h length %0h",
                      rsp_image_start, rsp_image_length);
               err_count++;
            end else begin
               image_want = image_q.pop_front();
               if (rsp_image_start !== image_want.start) begin
                  $error("image_start: expected %0h, actual %0h",
                         image_want.start, rsp_image_start);
                  err_count++;
               end
               if (rsp_image_length !== image_want.length) begin
                  $error("image_length: expected %0h, actual %0h",
                         image_want.length, rsp_image_length);
                  err_count++;
               end
               if (rsp_image_format !== image_want.format) begin
                  $error("image_format: expected %0h, actual %0h",
                         image_want.format, rsp_image_format);
                  err_count++;
               end
               if (rsp_last_of_run !== image_want.last) begin
                  $error("last_of_run: expected %0h, actual %0h",
                         image_want.last, rsp_last_of_run);
                  err_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (hold_receiver) begin
            rsp_stall <= 1'b1;
         end else if (idle_phase && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 14);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // long receiver hold-off so the result queue fills and input stalls
   initial begin
      while (req_count < 400) @(posedge clock);
      hold_receiver <= 1'b1;
      repeat (250) @(posedge clock);
      hold_receiver <= 1'b0;
   end

   initial begin
      #20000000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      carver_clear();
      // short block with extreme bytes
      blk_bytes = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
      seal_block();
      // exif then jfif header at the last judged position, both with ff d9 inside
      put_bytes({MARKER, SOI_CODE, MARKER, APP1_CODE, MARKER, EOI_CODE}, 6);
      put_bytes(EXIF_ID, 4);
      put_bytes({MARKER, SOI_CODE, MARKER, APP0_CODE, MARKER, EOI_CODE}, 6);
      put_bytes(JFIF_ID, 4);
      seal_block();
      foreach (staged_q[i]) pending_q.push_back(staged_q[i]);
      staged_q.delete();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // sender pause until all results are back
      while (pending_q.size() > 0 || req_valid || image_q.size() > 0) @(posedge clock);
      repeat (16) @(posedge clock);

      while (staged_q.size() < 880) build_block();
      total_reqs = req_count + staged_q.size();
      foreach (staged_q[i]) pending_q.push_back(staged_q[i]);

      while (pending_q.size() > 0 || req_valid || image_q.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (err_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
design/pjsc_pkg.sv
design/pjsc_header.sv
design/pjsc_region.sv
design/pjsc_rsp_fifo.sv
design/png_jpeg_stream_carver_top.sv
dv/png_jpeg_stream_carver_top_tb.sv
